// ===== hw/rtl/lbps_pkg.sv =====
// Shared types, mode table and phase codes for the LED blink pattern sequencer.
package lbps_pkg;

    localparam int unsigned MODE_COUNT = 6;

    localparam logic [2:0]  MODE_OFF    = 3'd0;
    localparam logic [15:0] FOREVER     = 16'hFFFF;
    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

    localparam logic [2:0] PH_NONE     = 3'd0;
    localparam logic [2:0] PH_ON       = 3'd1;
    localparam logic [2:0] PH_ON_WAIT  = 3'd2;
    localparam logic [2:0] PH_OFF      = 3'd3;
    localparam logic [2:0] PH_OFF_WAIT = 3'd4;
    localparam logic [2:0] PH_IDLE     = 3'd5;

    typedef struct packed {
        logic [15:0] on_ms;
        logic [15:0] off_ms;
        logic [15:0] flashes;
        logic [15:0] idle_ms;
        logic [15:0] bursts;
    } lbps_mode_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [2:0]  pattern;
        logic [15:0] flashes_left;
        logic [15:0] bursts_left;
        logic [16:0] elapsed_ms;
        logic [15:0] wait_ms;
        logic        lit;
    } lbps_led_t;

    localparam lbps_mode_t MODE_TABLE [MODE_COUNT] = '{
        '{16'd0,    FOREVER, FOREVER, FOREVER, FOREVER},
        '{FOREVER,  16'd0,   FOREVER, FOREVER, FOREVER},
        '{16'd1000, 16'd1000, FOREVER, 16'd0,  FOREVER},
        '{16'd100,  16'd100, 16'd0,   16'd0,   FOREVER},
        '{16'd500,  16'd500, 16'd0,   16'd500, FOREVER},
        '{16'd200,  16'd200, 16'd2,   16'd1000, FOREVER}
    };

    function automatic lbps_mode_t lbps_entry(input logic [2:0] m);
        lbps_mode_t e;
        if (m < 3'(MODE_COUNT))
            e = MODE_TABLE[m];
        else
            e = MODE_TABLE[MODE_OFF];
        return e;
    endfunction

    // A pattern with no on time starts in the off step.
    function automatic logic [2:0] lbps_first_phase(input lbps_mode_t e);
        return (e.on_ms == 16'd0) ? PH_OFF : PH_ON;
    endfunction

endpackage

// ===== hw/rtl/lbps_if.sv =====
// Valid/ready channel interfaces for requests in and results out.
interface lbps_req_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [1:0] led_index;
    logic [2:0] mode_request;

    modport source (output valid, output kind, output led_index, output mode_request,
                    input ready);
    modport sink (input valid, input kind, input led_index, input mode_request,
                  output ready);
endinterface

interface lbps_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] led_lit;
    logic       request_taken;

    modport source (output valid, output led_lit, output request_taken, input ready);
    modport sink (input valid, input led_lit, input request_taken, output ready);
endinterface

// ===== hw/rtl/led_blink_pattern_sequencer_top.sv =====
// LED blink pattern sequencer: per-LED pattern state and a registered result.
// A result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while ready is high; all LEDs update in parallel on a tick.
// Ready drops only while the result register is full and not being taken.
// Reset: every LED returns to mode off, unlit, no active step; result empty.
module led_blink_pattern_sequencer_top
    import lbps_pkg::*;
#(
    parameter int unsigned NUM_LEDS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    lbps_req_if.sink    in_ch,
    lbps_res_if.source  out_ch
);

    lbps_led_t           st_reg  [NUM_LEDS];
    lbps_led_t           st_next [NUM_LEDS];
    logic [NUM_LEDS-1:0] take;
    logic [NUM_LEDS-1:0] lit_next;
    logic [NUM_LEDS+3:0] lit_pad;

    logic       out_valid_reg;
    logic [3:0] led_lit_reg;
    logic       request_taken_reg;
    logic       in_fire;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    genvar i;
    generate
        for (i = 0; i < NUM_LEDS; i++)
        begin : g_led
            lbps_mode_t  ent;
            lbps_mode_t  req_ent;
            logic [16:0] elapsed_inc;
            logic        hit;

            // Only LEDs 0 to 3 can be addressed by a request.
            assign hit = (i < 4) && (in_ch.led_index == 2'(i));

            always_comb
            begin
                ent         = lbps_entry(st_reg[i].pattern);
                req_ent     = lbps_entry(in_ch.mode_request);
                st_next[i]  = st_reg[i];
                take[i]     = 1'b0;
                elapsed_inc = (st_reg[i].elapsed_ms != ELAPSED_MAX)
                              ? st_reg[i].elapsed_ms + 17'd1 : st_reg[i].elapsed_ms;
                if (in_fire)
                begin
                    if (in_ch.kind)
                    begin
                        if (hit && (in_ch.mode_request < 3'(MODE_COUNT))
                            && (st_reg[i].pattern != in_ch.mode_request))
                        begin
                            take[i]                 = 1'b1;
                            st_next[i].pattern      = in_ch.mode_request;
                            st_next[i].flashes_left = req_ent.flashes;
                            st_next[i].bursts_left  = req_ent.bursts;
                            st_next[i].phase        = lbps_first_phase(req_ent);
                            st_next[i].elapsed_ms   = 17'd0;
                            st_next[i].wait_ms      = 16'd0;
                        end
                    end
                    else if (elapsed_inc > {1'b0, st_reg[i].wait_ms})
                    begin
                        st_next[i].elapsed_ms = 17'd0;
                        case (st_reg[i].phase)
                            PH_ON:
                            begin
                                st_next[i].lit     = 1'b1;
                                st_next[i].phase   = PH_ON_WAIT;
                                st_next[i].wait_ms = ent.on_ms;
                            end
                            PH_ON_WAIT:
                            begin
                                if (ent.on_ms != FOREVER)
                                begin
                                    st_next[i].phase   = (ent.off_ms == 16'd0) ? PH_ON : PH_OFF;
                                    st_next[i].wait_ms = 16'd0;
                                end
                                else
                                    st_next[i].wait_ms = FOREVER;
                            end
                            PH_OFF:
                            begin
                                st_next[i].lit     = 1'b0;
                                st_next[i].phase   = PH_OFF_WAIT;
                                st_next[i].wait_ms = ent.off_ms;
                            end
                            PH_OFF_WAIT:
                            begin
                                if (ent.off_ms == FOREVER)
                                    st_next[i].wait_ms = FOREVER;
                                else if (st_reg[i].flashes_left == FOREVER)
                                begin
                                    st_next[i].phase   = lbps_first_phase(ent);
                                    st_next[i].wait_ms = 16'd0;
                                end
                                else if (st_reg[i].flashes_left <= 16'd1)
                                begin
                                    st_next[i].phase        = PH_IDLE;
                                    st_next[i].wait_ms      = ent.idle_ms;
                                    st_next[i].flashes_left = 16'd0;
                                end
                                else
                                begin
                                    st_next[i].flashes_left = st_reg[i].flashes_left - 16'd1;
                                    st_next[i].phase        = lbps_first_phase(ent);
                                    st_next[i].wait_ms      = 16'd0;
                                end
                            end
                            PH_IDLE:
                            begin
                                if (st_reg[i].bursts_left == FOREVER)
                                begin
                                    st_next[i].phase        = PH_ON;
                                    st_next[i].wait_ms      = 16'd0;
                                    st_next[i].flashes_left = ent.flashes;
                                end
                                else if (st_reg[i].bursts_left <= 16'd1)
                                begin
                                    // last burst done: fall back to mode off
                                    if (st_reg[i].pattern != MODE_OFF)
                                    begin
                                        st_next[i].pattern      = MODE_OFF;
                                        st_next[i].flashes_left = MODE_TABLE[MODE_OFF].flashes;
                                        st_next[i].bursts_left  = MODE_TABLE[MODE_OFF].bursts;
                                        st_next[i].phase =
                                            lbps_first_phase(MODE_TABLE[MODE_OFF]);
                                        st_next[i].wait_ms      = 16'd0;
                                    end
                                end
                                else
                                begin
                                    st_next[i].bursts_left  = st_reg[i].bursts_left - 16'd1;
                                    st_next[i].phase        = PH_ON;
                                    st_next[i].wait_ms      = 16'd0;
                                    st_next[i].flashes_left = ent.flashes;
                                end
                            end
                            default:
                                st_next[i].phase = PH_NONE;
                        endcase
                    end
                    else
                        st_next[i].elapsed_ms = elapsed_inc;
                end
            end

            assign lit_next[i] = st_next[i].lit;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    st_reg[i].phase        <= PH_NONE;
                    st_reg[i].pattern      <= MODE_OFF;
                    st_reg[i].flashes_left <= 16'd0;
                    st_reg[i].bursts_left  <= 16'd0;
                    st_reg[i].elapsed_ms   <= 17'd0;
                    st_reg[i].wait_ms      <= 16'd0;
                    st_reg[i].lit          <= 1'b0;
                end
                else
                    st_reg[i] <= st_next[i];
            end
        end
    endgenerate

    assign lit_pad = {4'b0000, lit_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            led_lit_reg       <= lit_pad[3:0];
            request_taken_reg <= |take;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.led_lit       = led_lit_reg;
    assign out_ch.request_taken = request_taken_reg;

endmodule

// ===== hw/rtl/lbps_checker.sv =====
// Port-level checks for the LED blink pattern sequencer, bound to the top level.
module lbps_checker
    import lbps_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       kind,
    input logic [1:0] led_index,
    input logic [2:0] mode_request,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] led_lit,
    input logic       request_taken
);

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(led_lit) && $stable(request_taken))
        else $error("result changed while stalled");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> out_valid)
        else $error("accepted request gave no result");

    a_tick_not_taken: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !kind |=> !request_taken)
        else $error("tick reported a taken request");

    a_bad_mode: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && kind && (mode_request >= 3'(MODE_COUNT)) |=> !request_taken)
        else $error("out-of-range mode was taken");

    a_repeat_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && kind) ##1 (in_acc && kind && led_index == $past(led_index)
            && mode_request == $past(mode_request)) |=> !request_taken)
        else $error("repeated mode request was taken");

endmodule

bind led_blink_pattern_sequencer_top lbps_checker u_lbps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .kind          (in_ch.kind),
    .led_index     (in_ch.led_index),
    .mode_request  (in_ch.mode_request),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .led_lit       (out_ch.led_lit),
    .request_taken (out_ch.request_taken)
);
